### rtl/c6502_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c6502_pkg
// Types, constants and decode function shared by the 6502 instruction engine.
// ----------------------------------------------------------------------------
package c6502_pkg;

	typedef enum logic [3:0] {
		PH_IDLE, PH_FETCH, PH_OPLO, PH_OPHI, PH_PTRLO, PH_PTRHI, PH_DATA,
		PH_POP1, PH_POP2, PH_POP3, PH_VECLO, PH_VECHI, PH_HALT
	} phase_t;

	typedef enum logic [3:0] {
		M_IMP, M_ACC, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY,
		M_IZX, M_IZY, M_REL, M_IND
	} mode_t;

	typedef enum logic [4:0] {
		K_ORA, K_AND, K_EOR, K_ADC, K_STA, K_LDA, K_CMP, K_SBC,
		K_ASL, K_ROL, K_LSR, K_ROR, K_STX, K_LDX, K_DEC, K_INC,
		K_BIT, K_JMP, K_STY, K_LDY, K_CPY, K_CPX, K_JSR, K_BRANCH, K_IMPL
	} kind_t;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  read_data;
	} item_t;

	typedef struct packed {
		logic        is_write;
		logic [15:0] bus_address;
		logic [7:0]  write_data;
		logic        is_fetch;
		logic        last;
		logic        halted;
	} beat_t;

	typedef struct packed {
		logic  ok;
		mode_t mode;
		kind_t kind;
	} dec_t;

	localparam logic [7:0]  SP_RESET  = 8'hFD;
	localparam logic [7:0]  P_RESET   = 8'h20;
	localparam logic [7:0]  F_N       = 8'h80;
	localparam logic [7:0]  F_V       = 8'h40;
	localparam logic [7:0]  F_U       = 8'h20;
	localparam logic [7:0]  F_B       = 8'h10;
	localparam logic [7:0]  F_I       = 8'h04;
	localparam logic [7:0]  F_Z       = 8'h02;
	localparam logic [7:0]  F_C       = 8'h01;
	localparam logic [7:0]  STACK_HI  = 8'h01;
	localparam logic [15:0] VEC_LO    = 16'hFFFE;
	localparam logic [15:0] VEC_HI    = 16'hFFFF;
	localparam logic [7:0]  OP_BRK    = 8'h00;
	localparam logic [7:0]  OP_RTI    = 8'h40;
	localparam logic [7:0]  OP_RTS    = 8'h60;
	localparam logic [7:0]  OP_PLA    = 8'h68;
	localparam logic [7:0]  OP_PLP    = 8'h28;
	localparam logic [7:0]  OP_PHP    = 8'h08;
	localparam logic [7:0]  OP_PHA    = 8'h48;
	localparam logic [7:0]  OP_CLC    = 8'h18;
	localparam logic [7:0]  OP_SEC    = 8'h38;
	localparam logic [7:0]  OP_CLI    = 8'h58;
	localparam logic [7:0]  OP_SEI    = 8'h78;
	localparam logic [7:0]  OP_CLV    = 8'hB8;
	localparam logic [7:0]  OP_CLD    = 8'hD8;
	localparam logic [7:0]  OP_SED    = 8'hF8;
	localparam logic [7:0]  OP_DEY    = 8'h88;
	localparam logic [7:0]  OP_INY    = 8'hC8;
	localparam logic [7:0]  OP_DEX    = 8'hCA;
	localparam logic [7:0]  OP_INX    = 8'hE8;
	localparam logic [7:0]  OP_TAX    = 8'hAA;
	localparam logic [7:0]  OP_TXA    = 8'h8A;
	localparam logic [7:0]  OP_TAY    = 8'hA8;
	localparam logic [7:0]  OP_TYA    = 8'h98;
	localparam logic [7:0]  OP_TSX    = 8'hBA;
	localparam logic [7:0]  OP_TXS    = 8'h9A;
	localparam logic [7:0]  OP_STA_IM = 8'h89;
	localparam logic [7:0]  OP_LDX_IM = 8'hA2;

	function automatic dec_t decode(input logic [7:0] c);
		dec_t       d;
		logic [2:0] a;
		logic [2:0] b;
		logic [1:0] g;
		a = c[7:5];
		b = c[4:2];
		g = c[1:0];
		d.ok = 1'b0;
		d.mode = M_IMP;
		d.kind = K_IMPL;
		unique case (g)
			2'd3: d.ok = 1'b0;
			2'd1: begin
				d.kind = kind_t'({2'b00, a});
				unique case (b)
					3'd0: d.mode = M_IZX;
					3'd1: d.mode = M_ZP;
					3'd2: d.mode = M_IMM;
					3'd3: d.mode = M_ABS;
					3'd4: d.mode = M_IZY;
					3'd5: d.mode = M_ZPX;
					3'd6: d.mode = M_ABY;
					default: d.mode = M_ABX;
				endcase
				d.ok = (c != OP_STA_IM);
			end
			2'd2: begin
				d.kind = kind_t'({2'b01, a});
				unique case (b)
					3'd0: begin d.mode = M_IMM; d.ok = (c == OP_LDX_IM); end
					3'd1: begin d.mode = M_ZP; d.ok = 1'b1; end
					3'd2: begin
						if (a < 3'd4) d.mode = M_ACC;
						else d.kind = K_IMPL;
						d.ok = 1'b1;
					end
					3'd3: begin d.mode = M_ABS; d.ok = 1'b1; end
					3'd5: begin
						d.mode = (a == 3'd4 || a == 3'd5) ? M_ZPY : M_ZPX;
						d.ok = 1'b1;
					end
					3'd6: begin d.kind = K_IMPL; d.ok = (c == OP_TXS || c == OP_TSX); end
					3'd7: begin d.mode = (a == 3'd5) ? M_ABY : M_ABX; d.ok = (a != 3'd4); end
					default: d.ok = 1'b0;
				endcase
			end
			default: begin
				if (b == 3'd4) begin
					d.mode = M_REL;
					d.kind = K_BRANCH;
					d.ok = 1'b1;
				end else if (b == 3'd2 || b == 3'd6) begin
					d.ok = 1'b1;
				end else begin
					unique case (a)
						3'd0: d.kind = K_IMPL;
						3'd1: d.kind = K_BIT;
						3'd2: d.kind = K_JMP;
						3'd3: d.kind = K_JMP;
						3'd4: d.kind = K_STY;
						3'd5: d.kind = K_LDY;
						3'd6: d.kind = K_CPY;
						default: d.kind = K_CPX;
					endcase
					unique case (b)
						3'd0: begin
							if (a == 3'd1) begin
								d.mode = M_ABS; d.kind = K_JSR; d.ok = 1'b1;
							end else if (a == 3'd0 || a == 3'd2 || a == 3'd3) begin
								d.kind = K_IMPL; d.ok = 1'b1;
							end else begin
								d.mode = M_IMM; d.ok = (a >= 3'd5);
							end
						end
						3'd1: begin d.mode = M_ZP; d.ok = (a == 3'd1 || a >= 3'd4); end
						3'd3: begin d.mode = (a == 3'd3) ? M_IND : M_ABS; d.ok = (a >= 3'd1); end
						3'd5: begin d.mode = M_ZPX; d.ok = (a == 3'd4 || a == 3'd5); end
						3'd7: begin d.mode = M_ABX; d.ok = (a == 3'd5); end
						default: d.ok = 1'b0;
					endcase
				end
			end
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

### rtl/c6502_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c6502_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface c6502_stream_if #(parameter int W = 9);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/c6502_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c6502_front
// Accepts input beats and start_pc writes; queues input items.
// ----------------------------------------------------------------------------
module c6502_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	c6502_stream_if.sink              in_ch,
	c6502_stream_if.sink              cfg_ch,
	output c6502_pkg::item_t          q_item,
	output logic [15:0]               q_pc,
	output logic                      q_valid,
	input  wire logic                 q_pop
);
	import c6502_pkg::*;

	logic [15:0] start_pc_q;
	item_t       slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = (cnt_q != 2'd2);
	assign push         = in_ch.valid && in_ch.ready;
	assign q_valid      = (cnt_q != 2'd0);
	assign q_item       = slot_q[rd_ptr_q];
	assign q_pc         = start_pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q <= '0;
			wr_ptr_q   <= 1'b0;
			rd_ptr_q   <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (cfg_ch.valid) start_pc_q <= cfg_ch.data;
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= item_t'(in_ch.data);
	end
endmodule
`default_nettype wire

### rtl/c6502_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c6502_back
// Instruction sequencer: executes one queued item, emits up to four beats.
// ----------------------------------------------------------------------------
module c6502_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  c6502_pkg::item_t          q_item,
	input  wire logic [15:0]          q_pc,
	input  wire logic                 q_valid,
	output logic                      q_pop,
	c6502_stream_if.source            out_ch
);
	import c6502_pkg::*;

	logic [15:0] pc_q, ea_q, ptr_q;
	logic [7:0]  a_q, x_q, y_q, p_q, sp_q, op_q;
	phase_t      ph_q;
	logic        halt_q;
	beat_t       buf_q [4];
	logic [2:0]  n_q;
	logic [1:0]  idx_q;

	logic [15:0] pc_n, ea_n, ptr_n;
	logic [7:0]  a_n, x_n, y_n, p_n, sp_n, op_n;
	phase_t      ph_n;
	logic        halt_n;
	beat_t       b_n [4];
	logic [2:0]  n_n;
	logic        busy, take;
	dec_t        dc, df;

	assign busy  = (n_q != 3'd0);
	assign take  = q_valid && !busy;
	assign q_pop = take;
	assign out_ch.valid = busy;
	assign out_ch.data  = buf_q[idx_q];

	always_comb begin
		logic [7:0]  d, r, v, rr;
		logic [8:0]  s;
		logic [15:0] t;
		logic        cout, wb;
		logic [7:0]  bf;
		d = q_item.read_data;
		pc_n = pc_q; ea_n = ea_q; ptr_n = ptr_q;
		a_n = a_q; x_n = x_q; y_n = y_q; p_n = p_q; sp_n = sp_q; op_n = op_q;
		ph_n = ph_q; halt_n = halt_q; n_n = '0;
		r = '0; v = '0; rr = '0; s = '0; t = '0; cout = 1'b0; wb = 1'b0; bf = '0;
		for (int i = 0; i < 4; i++) b_n[i] = '0;
		dc = decode(op_q);
		df = decode(d);

		if (!q_item.req_type) begin
			pc_n = q_pc; a_n = '0; x_n = '0; y_n = '0; sp_n = SP_RESET; p_n = P_RESET;
			halt_n = 1'b0;
			b_n[0] = '{1'b0, q_pc, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd1; ph_n = PH_FETCH;
		end else begin
			unique case (ph_q)
				PH_FETCH: begin
					op_n = d;
					if (!df.ok) begin
						halt_n = 1'b1; ph_n = PH_HALT;
						b_n[0] = '{1'b0, pc_q, 8'h00, 1'b0, 1'b0, 1'b1}; n_n = 3'd1;
					end else begin
						pc_n = pc_q + 16'd1;
						ph_n = PH_FETCH;
						if (df.mode == M_IMP) begin
							unique case (d)
								OP_BRK: begin
									t = pc_q + 16'd2;
									b_n[0] = '{1'b1, {STACK_HI, sp_q}, t[15:8], 1'b0, 1'b0, 1'b0};
									b_n[1] = '{1'b1, {STACK_HI, sp_q - 8'd1}, t[7:0], 1'b0,
										1'b0, 1'b0};
									b_n[2] = '{1'b1, {STACK_HI, sp_q - 8'd2}, p_q | F_B, 1'b0,
										1'b0, 1'b0};
									b_n[3] = '{1'b0, VEC_LO, 8'h00, 1'b0, 1'b0, 1'b0};
									sp_n = sp_q - 8'd3; n_n = 3'd4; ph_n = PH_VECLO;
								end
								OP_RTI, OP_RTS, OP_PLA, OP_PLP: begin
									sp_n = sp_q + 8'd1;
									b_n[0] = '{1'b0, {STACK_HI, sp_n}, 8'h00, 1'b0, 1'b0, 1'b0};
									n_n = 3'd1; ph_n = PH_POP1;
								end
								OP_PHP, OP_PHA: begin
									b_n[0] = '{1'b1, {STACK_HI, sp_q},
										(d == OP_PHP) ? (p_q | F_B) : a_q, 1'b0, 1'b0, 1'b0};
									sp_n = sp_q - 8'd1;
									b_n[1] = '{1'b0, pc_n, 8'h00, 1'b1, 1'b0, 1'b0};
									n_n = 3'd2;
								end
								default: begin
									unique case (d)
										OP_CLC: p_n = p_q & ~F_C;
										OP_SEC: p_n = p_q | F_C;
										OP_CLI: p_n = p_q & ~F_I;
										OP_SEI: p_n = p_q | F_I;
										OP_CLV: p_n = p_q & ~F_V;
										OP_CLD: p_n = p_q & 8'hF7;
										OP_SED: p_n = p_q | 8'h08;
										OP_DEY: begin y_n = y_q - 8'd1; r = y_n; wb = 1'b1; end
										OP_INY: begin y_n = y_q + 8'd1; r = y_n; wb = 1'b1; end
										OP_DEX: begin x_n = x_q - 8'd1; r = x_n; wb = 1'b1; end
										OP_INX: begin x_n = x_q + 8'd1; r = x_n; wb = 1'b1; end
										OP_TAX: begin x_n = a_q; r = a_q; wb = 1'b1; end
										OP_TXA: begin a_n = x_q; r = x_q; wb = 1'b1; end
										OP_TAY: begin y_n = a_q; r = a_q; wb = 1'b1; end
										OP_TYA: begin a_n = y_q; r = y_q; wb = 1'b1; end
										OP_TSX: begin x_n = sp_q; r = sp_q; wb = 1'b1; end
										OP_TXS: sp_n = x_q;
										default: ;
									endcase
									if (wb) p_n = (p_n & ~(F_N | F_Z)) | (r & F_N)
										| ((r == 8'h00) ? F_Z : 8'h00);
									b_n[0] = '{1'b0, pc_n, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd1;
								end
							endcase
						end else if (df.mode == M_ACC) begin
							cout = p_q[0]; r = a_q;
							unique case (df.kind)
								K_ASL: begin cout = a_q[7]; r = {a_q[6:0], 1'b0}; end
								K_ROL: begin cout = a_q[7]; r = {a_q[6:0], p_q[0]}; end
								K_LSR: begin cout = a_q[0]; r = {1'b0, a_q[7:1]}; end
								default: begin cout = a_q[0]; r = {p_q[0], a_q[7:1]}; end
							endcase
							a_n = r;
							p_n = (p_q & ~(F_N | F_Z | F_C)) | (r & F_N)
								| ((r == 8'h00) ? F_Z : 8'h00) | {7'd0, cout};
							b_n[0] = '{1'b0, pc_n, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd1;
						end else begin
							b_n[0] = '{1'b0, pc_n, 8'h00, 1'b0, 1'b0, 1'b0}; n_n = 3'd1;
							ph_n = PH_OPLO;
						end
					end
				end
				PH_OPLO, PH_OPHI, PH_PTRHI: begin
					wb = 1'b0;
					if (ph_q != PH_PTRHI) pc_n = pc_q + 16'd1;
					if (ph_q == PH_OPLO) begin
						unique case (dc.mode)
							M_IMM: begin v = d; ph_n = PH_DATA; wb = 1'b0; end
							M_REL: ;
							M_ZP:  begin ea_n = {8'h00, d}; wb = 1'b1; end
							M_ZPX: begin ea_n = {8'h00, d + x_q}; wb = 1'b1; end
							M_ZPY: begin ea_n = {8'h00, d + y_q}; wb = 1'b1; end
							M_IZX, M_IZY: begin
								ptr_n = {8'h00, (dc.mode == M_IZX) ? d + x_q : d};
								ph_n = PH_PTRLO;
							end
							default: begin ea_n = {8'h00, d}; ph_n = PH_OPHI; end
						endcase
					end else begin
						t = {d, ea_q[7:0]};
						if (ph_q == PH_OPHI && dc.mode == M_IND) begin
							ptr_n = t; ph_n = PH_PTRLO;
						end else if (ph_q == PH_PTRHI && dc.mode == M_IND) begin
							ph_n = PH_IDLE;
						end else begin
							if (dc.mode == M_ABX) t = t + {8'h00, x_q};
							else if (dc.mode == M_ABY || dc.mode == M_IZY) t = t + {8'h00, y_q};
							ea_n = t; wb = 1'b1; ph_n = PH_FETCH;
						end
					end
					if (ph_q == PH_OPLO && dc.mode == M_IMM) begin
						ph_n = PH_FETCH;
						v = d;
					end
					if (ph_q == PH_OPLO && dc.mode == M_REL) begin
						bf = (op_q[7:6] == 2'd0) ? F_N : (op_q[7:6] == 2'd1) ? F_V
							: (op_q[7:6] == 2'd2) ? F_C : F_Z;
						if (((p_q & bf) != 8'h00) == op_q[5])
							pc_n = pc_n + {{8{d[7]}}, d};
						b_n[0] = '{1'b0, pc_n, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd1;
						ph_n = PH_FETCH;
					end else if (ph_q == PH_OPLO && dc.mode == M_IMM) begin
						b_n[0] = '{1'b0, pc_n, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd1;
					end else if (ph_n == PH_IDLE) begin
						pc_n = t; ph_n = PH_FETCH;
						b_n[0] = '{1'b0, t, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd1;
					end else if (ph_n == PH_PTRLO || ph_n == PH_OPHI) begin
						b_n[0] = '{1'b0, (ph_n == PH_PTRLO) ? ptr_n : pc_n, 8'h00, 1'b0,
							1'b0, 1'b0};
						n_n = 3'd1;
					end else if (wb) begin
						ph_n = PH_FETCH;
						unique case (dc.kind)
							K_JMP: begin
								pc_n = ea_n;
								b_n[0] = '{1'b0, ea_n, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd1;
							end
							K_JSR: begin
								t = pc_n - 16'd1;
								b_n[0] = '{1'b1, {STACK_HI, sp_q}, t[15:8], 1'b0, 1'b0, 1'b0};
								b_n[1] = '{1'b1, {STACK_HI, sp_q - 8'd1}, t[7:0], 1'b0,
									1'b0, 1'b0};
								sp_n = sp_q - 8'd2; pc_n = ea_n;
								b_n[2] = '{1'b0, ea_n, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd3;
							end
							K_STA, K_STX, K_STY: begin
								b_n[0] = '{1'b1, ea_n, (dc.kind == K_STA) ? a_q
									: (dc.kind == K_STX) ? x_q : y_q, 1'b0, 1'b0, 1'b0};
								b_n[1] = '{1'b0, pc_n, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd2;
							end
							default: begin
								b_n[0] = '{1'b0, ea_n, 8'h00, 1'b0, 1'b0, 1'b0}; n_n = 3'd1;
								ph_n = PH_DATA;
							end
						endcase
					end
					if (ph_q == PH_OPLO && dc.mode == M_IMM) ph_n = PH_DATA;
				end
				PH_PTRLO: begin
					ea_n = {8'h00, d};
					t = (dc.mode == M_IND) ? ptr_q + 16'd1 : {8'h00, ptr_q[7:0] + 8'd1};
					b_n[0] = '{1'b0, t, 8'h00, 1'b0, 1'b0, 1'b0}; n_n = 3'd1;
					ph_n = PH_PTRHI;
				end
				PH_DATA: ;
				PH_POP1: begin
					ph_n = PH_FETCH;
					if (op_q == OP_PLA) begin
						a_n = d;
						p_n = (p_q & ~(F_N | F_Z)) | (d & F_N) | ((d == 8'h00) ? F_Z : 8'h00);
						b_n[0] = '{1'b0, pc_q, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd1;
					end else if (op_q == OP_PLP) begin
						p_n = d | F_U;
						b_n[0] = '{1'b0, pc_q, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd1;
					end else begin
						if (op_q == OP_RTI) p_n = d | F_B;
						else ea_n = {8'h00, d};
						sp_n = sp_q + 8'd1;
						b_n[0] = '{1'b0, {STACK_HI, sp_n}, 8'h00, 1'b0, 1'b0, 1'b0}; n_n = 3'd1;
						ph_n = PH_POP2;
					end
				end
				PH_POP2: begin
					if (op_q == OP_RTI) begin
						ea_n = {8'h00, d};
						sp_n = sp_q + 8'd1;
						b_n[0] = '{1'b0, {STACK_HI, sp_n}, 8'h00, 1'b0, 1'b0, 1'b0}; n_n = 3'd1;
						ph_n = PH_POP3;
					end else begin
						pc_n = {d, ea_q[7:0]} + 16'd1;
						b_n[0] = '{1'b0, pc_n, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd1;
						ph_n = PH_FETCH;
					end
				end
				PH_POP3, PH_VECHI: begin
					pc_n = {d, ea_q[7:0]};
					if (ph_q == PH_VECHI) p_n = p_q | F_I;
					b_n[0] = '{1'b0, pc_n, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd1;
					ph_n = PH_FETCH;
				end
				PH_VECLO: begin
					ea_n = {8'h00, d};
					b_n[0] = '{1'b0, VEC_HI, 8'h00, 1'b0, 1'b0, 1'b0}; n_n = 3'd1;
					ph_n = PH_VECHI;
				end
				PH_HALT: begin
					b_n[0] = '{1'b0, pc_q, 8'h00, 1'b0, 1'b0, 1'b1}; n_n = 3'd1;
				end
				default: ;
			endcase

			if (ph_q == PH_DATA || (ph_q == PH_OPLO && dc.mode == M_IMM)) begin
				ph_n = PH_FETCH;
				if (ph_q == PH_DATA && (dc.kind == K_ASL || dc.kind == K_ROL
					|| dc.kind == K_LSR || dc.kind == K_ROR || dc.kind == K_DEC
					|| dc.kind == K_INC)) begin
					cout = p_q[0];
					unique case (dc.kind)
						K_ASL: begin cout = d[7]; rr = {d[6:0], 1'b0}; end
						K_ROL: begin cout = d[7]; rr = {d[6:0], p_q[0]}; end
						K_LSR: begin cout = d[0]; rr = {1'b0, d[7:1]}; end
						K_ROR: begin cout = d[0]; rr = {p_q[0], d[7:1]}; end
						K_DEC: rr = d - 8'd1;
						default: rr = d + 8'd1;
					endcase
					p_n = (p_q & ~(F_N | F_Z | F_C)) | (rr & F_N)
						| ((rr == 8'h00) ? F_Z : 8'h00) | {7'd0, cout};
					b_n[0] = '{1'b1, ea_q, rr, 1'b0, 1'b0, 1'b0};
					b_n[1] = '{1'b0, pc_q, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd2;
				end else begin
					v = d;
					wb = 1'b1; r = 8'h00; cout = 1'b0;
					unique case (dc.kind)
						K_ORA: begin a_n = a_q | v; r = a_n; end
						K_AND: begin a_n = a_q & v; r = a_n; end
						K_EOR: begin a_n = a_q ^ v; r = a_n; end
						K_ADC, K_SBC: begin
							rr = (dc.kind == K_SBC) ? ~v : v;
							s = {1'b0, a_q} + {1'b0, rr} + {8'd0, p_q[0]};
							a_n = s[7:0]; r = s[7:0];
							p_n = (p_q & ~(F_V | F_C)) | {7'd0, s[8]}
								| (((~(a_q ^ rr)) & (a_q ^ s[7:0]) & 8'h80) != 8'h00 ? F_V : 8'h00);
						end
						K_LDA: begin a_n = v; r = v; end
						K_LDX: begin x_n = v; r = v; end
						K_LDY: begin y_n = v; r = v; end
						K_CMP, K_CPX, K_CPY: begin
							rr = (dc.kind == K_CMP) ? a_q : (dc.kind == K_CPX) ? x_q : y_q;
							r = rr - v;
							p_n = (p_q & ~F_C) | ((rr >= v) ? F_C : 8'h00);
						end
						K_BIT: begin
							wb = 1'b0;
							p_n = (p_q & ~(F_N | F_V | F_Z)) | (v & (F_N | F_V))
								| (((a_q & v) == 8'h00) ? F_Z : 8'h00);
						end
						default: wb = 1'b0;
					endcase
					if (wb) p_n = (p_n & ~(F_N | F_Z)) | (r & F_N)
						| ((r == 8'h00) ? F_Z : 8'h00);
					b_n[0] = '{1'b0, pc_n, 8'h00, 1'b1, 1'b0, 1'b0}; n_n = 3'd1;
				end
			end
			if (ph_q == PH_IDLE) n_n = '0;
		end
		if (n_n != 3'd0) b_n[n_n[1:0] - 2'd1].last = 1'b1;
		if (n_n == 3'd4) b_n[3].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0; ea_q <= '0; ptr_q <= '0;
			a_q <= '0; x_q <= '0; y_q <= '0; p_q <= P_RESET; sp_q <= SP_RESET; op_q <= '0;
			ph_q <= PH_IDLE; halt_q <= 1'b0; n_q <= '0; idx_q <= '0;
		end else if (take) begin
			if (q_item.req_type == 1'b0 || ph_q != PH_IDLE) begin
				pc_q <= pc_n; ea_q <= ea_n; ptr_q <= ptr_n;
				a_q <= a_n; x_q <= x_n; y_q <= y_n; p_q <= p_n; sp_q <= sp_n; op_q <= op_n;
				ph_q <= ph_n; halt_q <= halt_n;
			end
			n_q <= n_n; idx_q <= '0;
		end else if (busy && out_ch.ready) begin
			n_q <= n_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) for (int i = 0; i < 4; i++) buf_q[i] <= b_n[i];
	end
endmodule
`default_nettype wire

### rtl/cpu6502_instruction_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpu6502_instruction_engine_top
// 6502 instruction engine driven one bus response at a time.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_ch    in   req_type, read_data
// cfg_ch   in   start_pc
// out_ch   out  is_write, bus_address, write_data, is_fetch, last, halted
// The sequencer takes a new item only after the beat buffer has drained.
// Up to four beats per item; the beat buffer sets the rate.
// A two-entry queue takes input beats while the beat buffer drains.
// Reset clears control state and sets architectural state to reset values; cfg writes always accepted.
module cpu6502_instruction_engine_top (
	input  wire logic      clk,
	input  wire logic      arst_n,
	c6502_stream_if.sink   in_ch,
	c6502_stream_if.sink   cfg_ch,
	c6502_stream_if.source out_ch
);
	import c6502_pkg::*;

	item_t       q_item;
	logic [15:0] q_pc;
	logic        q_valid, q_pop;

	c6502_front u_front (.clk, .arst_n, .in_ch, .cfg_ch, .q_item, .q_pc, .q_valid, .q_pop);
	c6502_back  u_back  (.clk, .arst_n, .q_item, .q_pc, .q_valid, .q_pop, .out_ch);

`ifndef SYNTHESIS
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop on empty queue");
	a_no_write_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data[27]) |-> !out_ch.data[1])
		else $error("write beat marked last");
`endif
endmodule
`default_nettype wire
